// ----- rtl/core/tnss_pkg.sv -----
// Shared types, constants and helper functions for the top-N score selector.
package tnss_pkg;

    localparam int TOP_MAX_DEF      = 8;
    localparam int MAX_ELEMENTS_DEF = 65536;
    localparam int SCORE_W          = 32;
    localparam int INDEX_W          = 16;
    localparam int KEEP_W           = 4;
    localparam int ADDR_W           = 3;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [31:0] THRESHOLD_RESET = 32'h3A83126F;
    localparam logic [3:0]  KEEP_RESET      = 4'd5;

    localparam logic [ADDR_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [ADDR_W-1:0] REG_KEEP      = 3'd4;

    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_REPORT,
        BK_EMPTY
    } back_state_t;

    // Classified request handed from front to back.
    typedef struct packed
    {
        logic                 is_end;
        logic [SCORE_W-1:0]   bits;
        logic [SCORE_W-1:0]   key;
        logic [INDEX_W-1:0]   index;
    } cmd_t;

    function automatic logic is_nan(input logic [31:0] b);
        return b[30:0] > 31'h7F800000;
    endfunction

    function automatic logic [31:0] order_key(input logic [31:0] b);
        logic [31:0] k;
        if (b[30:0] == 31'd0)
            k = 32'h80000000;
        else if (b[31])
            k = ~b;
        else
            k = b | 32'h80000000;
        return k;
    endfunction

endpackage

// ----- rtl/core/tnss_if.sv -----
// Valid/ready stream interfaces for requests and results.
interface tnss_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] score_bits;
    modport source (output valid, kind, score_bits, input ready);
    modport sink   (input valid, kind, score_bits, output ready);
endinterface

interface tnss_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_score;
    logic [15:0] out_index;
    logic        out_valid;
    logic        out_last;
    modport source (output valid, out_score, out_index, out_valid, out_last, input ready);
    modport sink   (input valid, out_score, out_index, out_valid, out_last, output ready);
endinterface

// ----- rtl/core/tnss_front.sv -----
// Front end: numbers scores, drops NaN and below-threshold scores, queues commands.
module tnss_front #(
    parameter int MAX_ELEMENTS = tnss_pkg::MAX_ELEMENTS_DEF
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [31:0]         score_bits,
    input  logic [31:0]         threshold,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output tnss_pkg::cmd_t      cmd
);
    localparam int LIM_INT = (MAX_ELEMENTS - 1 > 65535) ? 65535 : MAX_ELEMENTS - 1;
    localparam logic [15:0] IDX_LIM = 16'(LIM_INT);
    localparam int QD = tnss_pkg::QUEUE_DEPTH;
    localparam int PW = $clog2(QD);

    logic [15:0] count_reg, count_next;
    tnss_pkg::cmd_t q_mem [QD];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   fill_reg;
    logic accept, push, pop, below;
    tnss_pkg::cmd_t new_cmd;

    assign in_ready  = (fill_reg != (PW+1)'(QD));
    assign accept    = in_valid && in_ready;
    assign cmd_valid = (fill_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_mem[rp_reg];

    always_comb
    begin
        below = !tnss_pkg::is_nan(threshold) &&
                (tnss_pkg::order_key(score_bits) < tnss_pkg::order_key(threshold));
        new_cmd.is_end = kind;
        new_cmd.bits   = score_bits;
        new_cmd.key    = tnss_pkg::order_key(score_bits);
        new_cmd.index  = count_reg;
        push = accept && (kind || !(tnss_pkg::is_nan(score_bits) || below));
        if (!accept)
            count_next = count_reg;
        else if (kind)
            count_next = '0;
        else if (count_reg < IDX_LIM)
            count_next = count_reg + 16'd1;
        else
            count_next = IDX_LIM;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            wp_reg    <= '0;
            rp_reg    <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wp_reg <= wp_reg + PW'(1);
            if (pop)
                rp_reg <= rp_reg + PW'(1);
            fill_reg <= fill_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wp_reg] <= new_cmd;
    end
endmodule

// ----- rtl/core/tnss_back.sv -----
// Back end: sorted insertion list and report sequencer with output register.
module tnss_back #(
    parameter int TOP_MAX = tnss_pkg::TOP_MAX_DEF
)(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  tnss_pkg::cmd_t  cmd,
    input  logic [3:0]      keep_count,
    output logic            res_valid,
    input  logic            res_ready,
    output logic [31:0]     out_score,
    output logic [15:0]     out_index,
    output logic            out_valid,
    output logic            out_last
);
    localparam int TW = $clog2(TOP_MAX + 1);

    logic [31:0] sc_reg [TOP_MAX];
    logic [31:0] ky_reg [TOP_MAX];
    logic [15:0] ix_reg [TOP_MAX];
    logic [TW-1:0] total_reg, total_next, rd_reg, rd_next, keep;
    tnss_pkg::back_state_t state_reg, state_next;
    logic ov_reg, ov_next;
    logic [31:0] os_reg, os_next;
    logic [15:0] oi_reg, oi_next;
    logic ovl_reg, ovl_next, ol_reg, ol_next;
    logic [TOP_MAX-1:0] above;
    logic [TW-1:0] n_cur, pos, new_n;
    logic slot_free, do_ins;

    assign res_valid = ov_reg;
    assign out_score = os_reg;
    assign out_index = oi_reg;
    assign out_valid = ovl_reg;
    assign out_last  = ol_reg;
    assign slot_free = !ov_reg || res_ready;

    always_comb
    begin
        if (keep_count == 4'd0)
            keep = TW'(1);
        else if (32'(keep_count) > TOP_MAX)
            keep = TW'(TOP_MAX);
        else
            keep = TW'(keep_count);
        n_cur = (total_reg < keep) ? total_reg : keep;
        for (int i = 0; i < TOP_MAX; i++)
            above[i] = (TW'(i) >= n_cur) || (cmd.key > ky_reg[i]) ||
                       (cmd.key == ky_reg[i] && cmd.index > ix_reg[i]);
        pos = TW'(TOP_MAX);
        for (int i = TOP_MAX - 1; i >= 0; i--)
            if (above[i])
                pos = TW'(i);
        new_n = (n_cur < keep) ? n_cur + TW'(1) : keep;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tnss_pkg::BK_IDLE:
                if (cmd_valid && cmd.is_end)
                    state_next = (n_cur == '0) ? tnss_pkg::BK_EMPTY : tnss_pkg::BK_REPORT;
            tnss_pkg::BK_REPORT:
                if (slot_free && rd_reg + TW'(1) == total_reg)
                    state_next = tnss_pkg::BK_IDLE;
            tnss_pkg::BK_EMPTY:
                if (slot_free)
                    state_next = tnss_pkg::BK_IDLE;
            default:
                state_next = tnss_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_ready  = 1'b0;
        do_ins     = 1'b0;
        total_next = total_reg;
        rd_next    = rd_reg;
        ov_next    = ov_reg && !res_ready;
        os_next    = os_reg;
        oi_next    = oi_reg;
        ovl_next   = ovl_reg;
        ol_next    = ol_reg;
        case (state_reg)
            tnss_pkg::BK_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid && cmd.is_end)
                begin
                    total_next = n_cur;
                    rd_next    = '0;
                end
                else if (cmd_valid && pos < keep)
                begin
                    do_ins     = 1'b1;
                    total_next = new_n;
                end
                else if (cmd_valid)
                    total_next = n_cur;
            end
            tnss_pkg::BK_REPORT:
                if (slot_free)
                begin
                    ov_next  = 1'b1;
                    os_next  = sc_reg[rd_reg[$clog2(TOP_MAX > 1 ? TOP_MAX : 2)-1:0]];
                    oi_next  = ix_reg[rd_reg[$clog2(TOP_MAX > 1 ? TOP_MAX : 2)-1:0]];
                    ovl_next = 1'b1;
                    ol_next  = (rd_reg + TW'(1) == total_reg);
                    rd_next  = rd_reg + TW'(1);
                    if (ol_next)
                        total_next = '0;
                end
            tnss_pkg::BK_EMPTY:
                if (slot_free)
                begin
                    ov_next  = 1'b1;
                    os_next  = '0;
                    oi_next  = '0;
                    ovl_next = 1'b0;
                    ol_next  = 1'b1;
                end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tnss_pkg::BK_IDLE;
            total_reg <= '0;
            rd_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            rd_reg    <= rd_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        os_reg  <= os_next;
        oi_reg  <= oi_next;
        ovl_reg <= ovl_next;
        ol_reg  <= ol_next;
        if (do_ins)
        begin
            for (int i = 0; i < TOP_MAX; i++)
            begin
                if (TW'(i) == pos)
                begin
                    sc_reg[i] <= cmd.bits;
                    ky_reg[i] <= cmd.key;
                    ix_reg[i] <= cmd.index;
                end
                else if (TW'(i) > pos && i > 0)
                begin
                    sc_reg[i] <= sc_reg[(i > 0) ? i - 1 : 0];
                    ky_reg[i] <= ky_reg[(i > 0) ? i - 1 : 0];
                    ix_reg[i] <= ix_reg[(i > 0) ? i - 1 : 0];
                end
            end
        end
    end
endmodule

// ----- rtl/core/top_n_score_selector.sv -----
// Top level of the streaming top-N score selector.
//   channel | dir | handshake     | payload
//   req     | in  | valid/ready   | kind, score_bits
//   res     | out | valid/ready   | out_score, out_index, out_valid, out_last
//   apb     | in  | psel/penable  | paddr, pwdata -> prdata
// A score is placed by the back end's parallel-compare insert.
// A report holds the back end: it takes the end request, then gives one result per kept entry (at most
// keep_count, clamped to TOP_MAX, zero read as one), or the single result of an empty list.
// A four-entry command queue decouples scoring from reporting; a stalled result holds the report.
// Reset clears the list count and element counter and loads the threshold and keep registers; no clearing pass.
module top_n_score_selector #(
    parameter int TOP_MAX      = tnss_pkg::TOP_MAX_DEF,
    parameter int MAX_ELEMENTS = tnss_pkg::MAX_ELEMENTS_DEF
)(
    input  logic                    clk,
    input  logic                    rst_n,
    tnss_in_if.sink                 req,
    tnss_out_if.source              res,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [tnss_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    logic [31:0] thr_reg;
    logic [3:0]  keep_reg;
    logic        cmd_valid, cmd_ready;
    tnss_pkg::cmd_t cmd;

    assign pready = 1'b1;

    always_comb
    begin
        case (paddr)
            tnss_pkg::REG_THRESHOLD: prdata = thr_reg;
            tnss_pkg::REG_KEEP:      prdata = {28'd0, keep_reg};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= tnss_pkg::THRESHOLD_RESET;
            keep_reg <= tnss_pkg::KEEP_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == tnss_pkg::REG_THRESHOLD)
                thr_reg <= pwdata;
            else if (paddr == tnss_pkg::REG_KEEP)
                keep_reg <= pwdata[3:0];
        end
    end

    tnss_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .kind       (req.kind),
        .score_bits (req.score_bits),
        .threshold  (thr_reg),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    tnss_back #(.TOP_MAX(TOP_MAX)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .keep_count (keep_reg),
        .res_valid  (res.valid),
        .res_ready  (res.ready),
        .out_score  (res.out_score),
        .out_index  (res.out_index),
        .out_valid  (res.out_valid),
        .out_last   (res.out_last)
    );

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.out_valid) |-> res.out_last)
        else $error("empty report result without last flag");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |=> (res.valid && $stable(res.out_index)))
        else $error("result changed while stalled");

    a_cmd_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_ready) |=> cmd_valid)
        else $error("queued command lost");
endmodule
